// ===== hdl/fdrb_pkg.sv =====
// Shared types and constants for the fractional delay ring buffer.
`timescale 1ns / 1ps
package fdrb_pkg;

  localparam int REQ_BITS    = 3;
  localparam int CHAN_BITS   = 1;
  localparam int SAMPLE_BITS = 16;
  localparam int DELAY_BITS  = 18;
  localparam int FRAC_BITS   = 8;
  localparam int STATUS_BITS = 2;
  localparam int WHOLE_BITS  = DELAY_BITS - FRAC_BITS;

  localparam logic [REQ_BITS-1:0] REQ_WRITE     = 3'd0;
  localparam logic [REQ_BITS-1:0] REQ_READ      = 3'd1;
  localparam logic [REQ_BITS-1:0] REQ_SET_DELAY = 3'd2;
  localparam logic [REQ_BITS-1:0] REQ_ADV_WRITE = 3'd3;
  localparam logic [REQ_BITS-1:0] REQ_CLEAR     = 3'd4;

  localparam logic [STATUS_BITS-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_BITS-1:0] STATUS_OVERRUN  = 2'd1;
  localparam logic [STATUS_BITS-1:0] STATUS_UNDERRUN = 2'd2;

  typedef struct packed {
    logic [REQ_BITS-1:0]           req_type;
    logic [CHAN_BITS-1:0]          channel;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic [DELAY_BITS-1:0]         delay_amount;
  } req_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic [STATUS_BITS-1:0]        status;
  } rsp_t;

  typedef enum logic [1:0] {
    ALU_ADD      = 2'd0,
    ALU_SUB      = 2'd1,
    ALU_ADD_WRAP = 2'd2,
    ALU_SUB_WRAP = 2'd3
  } alu_op_e;

endpackage

// ===== hdl/fdrb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module fdrb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/fdrb_alu.sv =====
// Shared add/subtract unit with optional modular wrap, used by the sequencer.
`timescale 1ns / 1ps
module fdrb_alu #(
  parameter int W = 18
) (
  input  fdrb_pkg::alu_op_e op_i,
  input  logic signed [W-1:0] a_i,
  input  logic signed [W-1:0] b_i,
  input  logic signed [W-1:0] m_i,
  output logic signed [W-1:0] res_o,
  output logic                neg_o
);

  logic signed [W-1:0] sum;
  logic signed [W-1:0] over;
  logic                sub;

  always_comb begin
    sub  = (op_i == fdrb_pkg::ALU_SUB) || (op_i == fdrb_pkg::ALU_SUB_WRAP);
    sum  = sub ? (a_i - b_i) : (a_i + b_i);
    over = sum - m_i;
    case (op_i)
      fdrb_pkg::ALU_ADD:      res_o = sum;
      fdrb_pkg::ALU_SUB:      res_o = sum;
      // operands below the modulus: one correction is enough
      fdrb_pkg::ALU_ADD_WRAP: res_o = over[W-1] ? sum : over;
      fdrb_pkg::ALU_SUB_WRAP: res_o = sum[W-1] ? (sum + m_i) : sum;
      default:                res_o = sum;
    endcase
    neg_o = sum[W-1];
  end

endmodule

// ===== hdl/fractional_delay_ring_buffer.sv =====
// Top level: per-channel ring buffer with linear-interpolated fractional read.
//
//   channel  | dir | handshake               | payload
//   ---------+-----+-------------------------+-----------------------------
//   request  | in  | in_valid_i / in_stall_o | in_data_i  (fdrb_pkg::req_t)
//   response | out | out_valid_o/out_stall_i | out_data_o (fdrb_pkg::rsp_t)
//
// One request at a time through a sequencer around one shared adder and a
// single-port-read sample RAM. A read issues two RAM reads, then subtracts,
// multiplies and adds; set delay and advance write reduce the whole delay
// modulo the depth by repeated subtraction before the pointer update; clear
// runs a RAM zeroing sweep.
// After reset the same sweep runs with in_stall_o high. The result sits in
// an output register, so a stalled response holds only the next request's
// completion, not its acceptance.
`timescale 1ns / 1ps
module fractional_delay_ring_buffer #(
  parameter int BUFFER_DEPTH = 1024,
  parameter int NUM_CHANNELS = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  fdrb_pkg::req_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output fdrb_pkg::rsp_t out_data_o
);

  localparam int SB       = fdrb_pkg::SAMPLE_BITS;
  localparam int FB       = fdrb_pkg::FRAC_BITS;
  localparam int WB       = fdrb_pkg::WHOLE_BITS;
  localparam int PTR_W    = $clog2(BUFFER_DEPTH);
  localparam int RAM_AW   = PTR_W + fdrb_pkg::CHAN_BITS;
  localparam int RAM_D    = 2 ** RAM_AW;
  localparam int NRING    = 2 ** fdrb_pkg::CHAN_BITS;
  localparam int PROD_W   = SB + FB + 2;
  localparam int W_A      = SB + 2;
  localparam int W_B      = (PTR_W + 2 > WB + 2) ? PTR_W + 2 : WB + 2;
  localparam int ALU_W    = (W_A > W_B) ? W_A : W_B;
  localparam logic signed [ALU_W-1:0] DEPTH_V = ALU_W'(BUFFER_DEPTH);
  localparam logic [RAM_AW-1:0] CLR_LAST = {RAM_AW{1'b1}};

  typedef enum logic [9:0] {
    ST_CLEAR = 10'b0000000001,
    ST_IDLE  = 10'b0000000010,
    ST_EXEC  = 10'b0000000100,
    ST_RD2   = 10'b0000001000,
    ST_DIFF  = 10'b0000010000,
    ST_MUL   = 10'b0000100000,
    ST_SUM   = 10'b0001000000,
    ST_MOD   = 10'b0010000000,
    ST_PTR   = 10'b0100000000,
    ST_DONE  = 10'b1000000000
  } state_e;

  state_e                   state_q, state_d;
  fdrb_pkg::req_t           req_q, req_d;
  fdrb_pkg::rsp_t           res_q, res_d;
  fdrb_pkg::rsp_t           out_q, out_d;
  logic                     out_valid_q, out_valid_d;
  logic [PTR_W-1:0]         wp_q [NRING];
  logic [PTR_W-1:0]         wp_d [NRING];
  logic [PTR_W-1:0]         rp_q [NRING];
  logic [PTR_W-1:0]         rp_d [NRING];
  logic [FB-1:0]            frac_q [NRING];
  logic [FB-1:0]            frac_d [NRING];
  logic [PTR_W-1:0]         rpn_q, rpn_d;
  logic [WB-1:0]            whole_q, whole_d;
  logic signed [SB-1:0]     s1_q, s1_d;
  logic signed [SB:0]       diff_q, diff_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic [RAM_AW-1:0]        clr_cnt_q, clr_cnt_d;
  logic                     clr_rsp_q, clr_rsp_d;

  fdrb_pkg::alu_op_e        alu_op;
  logic signed [ALU_W-1:0]  alu_a, alu_b, alu_res;
  logic                     alu_neg;

  logic                     ram_we;
  logic [RAM_AW-1:0]        ram_waddr, ram_raddr;
  logic [SB-1:0]            ram_wdata, ram_rdata;

  logic [fdrb_pkg::CHAN_BITS-1:0] ch;
  logic                     ch_ok;
  logic [PTR_W-1:0]         alu_ptr;

  fdrb_alu #(.W(ALU_W)) u_alu (
    .op_i  (alu_op),
    .a_i   (alu_a),
    .b_i   (alu_b),
    .m_i   (DEPTH_V),
    .res_o (alu_res),
    .neg_o (alu_neg)
  );

  fdrb_ram #(.WIDTH(SB), .DEPTH(RAM_D)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign ch      = req_q.channel;
  assign ch_ok   = 32'(req_q.channel) < NUM_CHANNELS;
  assign alu_ptr = alu_res[PTR_W-1:0];

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    wp_d        = wp_q;
    rp_d        = rp_q;
    frac_d      = frac_q;
    rpn_d       = rpn_q;
    whole_d     = whole_q;
    s1_d        = s1_q;
    diff_d      = diff_q;
    prod_d      = prod_q;
    clr_cnt_d   = clr_cnt_q;
    clr_rsp_d   = clr_rsp_q;
    alu_op      = fdrb_pkg::ALU_ADD;
    alu_a       = '0;
    alu_b       = '0;
    ram_we      = 1'b0;
    ram_waddr   = {ch, wp_q[ch]};
    ram_wdata   = req_q.sample_in;
    ram_raddr   = {ch, rp_q[ch]};

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_q;
        ram_wdata = '0;
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == CLR_LAST) begin
          clr_rsp_d = 1'b0;
          res_d     = '{sample_out: '0, status: fdrb_pkg::STATUS_OK};
          state_d   = clr_rsp_q ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          req_d   = in_data_i;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        res_d   = '{sample_out: '0, status: fdrb_pkg::STATUS_OK};
        state_d = ST_DONE;
        if (req_q.req_type == fdrb_pkg::REQ_CLEAR) begin
          for (int i = 0; i < NRING; i++) begin
            wp_d[i] = '0;
            rp_d[i] = '0;
          end
          clr_cnt_d = '0;
          clr_rsp_d = 1'b1;
          state_d   = ST_CLEAR;
        end else if (ch_ok) begin
          case (req_q.req_type)
            fdrb_pkg::REQ_WRITE: begin
              alu_op = fdrb_pkg::ALU_ADD_WRAP;
              alu_a  = ALU_W'(wp_q[ch]);
              alu_b  = ALU_W'(1);
              if (alu_ptr == rp_q[ch]) begin
                res_d.status = fdrb_pkg::STATUS_OVERRUN;
              end else begin
                ram_we   = 1'b1;
                wp_d[ch] = alu_ptr;
              end
            end
            fdrb_pkg::REQ_READ: begin
              if (rp_q[ch] == wp_q[ch]) begin
                res_d.status = fdrb_pkg::STATUS_UNDERRUN;
              end else begin
                alu_op  = fdrb_pkg::ALU_ADD_WRAP;
                alu_a   = ALU_W'(rp_q[ch]);
                alu_b   = ALU_W'(1);
                rpn_d   = alu_ptr;
                state_d = ST_RD2;
              end
            end
            fdrb_pkg::REQ_SET_DELAY, fdrb_pkg::REQ_ADV_WRITE: begin
              whole_d = req_q.delay_amount[fdrb_pkg::DELAY_BITS-1:FB];
              state_d = ST_MOD;
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_RD2: begin
        // s1 from the first read lands now; issue the second read
        ram_raddr = {ch, rpn_q};
        s1_d      = $signed(ram_rdata);
        state_d   = ST_DIFF;
      end
      ST_DIFF: begin
        alu_op  = fdrb_pkg::ALU_SUB;
        alu_a   = ALU_W'($signed(ram_rdata));
        alu_b   = ALU_W'(s1_q);
        diff_d  = alu_res[SB:0];
        state_d = ST_MUL;
      end
      ST_MUL: begin
        prod_d  = PROD_W'($signed({1'b0, frac_q[ch]}) * diff_q);
        state_d = ST_SUM;
      end
      ST_SUM: begin
        // arithmetic shift gives the floor of the scaled product
        alu_op           = fdrb_pkg::ALU_ADD;
        alu_a            = ALU_W'(s1_q);
        alu_b            = ALU_W'(prod_q >>> FB);
        res_d.sample_out = alu_res[SB-1:0];
        rp_d[ch]         = rpn_q;
        state_d          = ST_DONE;
      end
      ST_MOD: begin
        // reduce the whole delay modulo the depth by repeated subtraction
        alu_op = fdrb_pkg::ALU_SUB;
        alu_a  = ALU_W'(whole_q);
        alu_b  = DEPTH_V;
        if (!alu_neg) begin
          whole_d = alu_res[WB-1:0];
        end else begin
          state_d = ST_PTR;
        end
      end
      ST_PTR: begin
        alu_a = ALU_W'(wp_q[ch]);
        alu_b = ALU_W'(whole_q);
        if (req_q.req_type == fdrb_pkg::REQ_SET_DELAY) begin
          alu_op     = fdrb_pkg::ALU_SUB_WRAP;
          rp_d[ch]   = alu_ptr;
          frac_d[ch] = req_q.delay_amount[FB-1:0];
        end else begin
          alu_op   = fdrb_pkg::ALU_ADD_WRAP;
          wp_d[ch] = alu_ptr;
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
      clr_cnt_q   <= '0;
      clr_rsp_q   <= 1'b0;
      for (int i = 0; i < NRING; i++) begin
        wp_q[i]   <= '0;
        rp_q[i]   <= '0;
        frac_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      clr_cnt_q   <= clr_cnt_d;
      clr_rsp_q   <= clr_rsp_d;
      wp_q        <= wp_d;
      rp_q        <= rp_d;
      frac_q      <= frac_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    res_q   <= res_d;
    out_q   <= out_d;
    rpn_q   <= rpn_d;
    whole_q <= whole_d;
    s1_q    <= s1_d;
    diff_q  <= diff_d;
    prod_q  <= prod_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hdl/fdrb_checker.sv =====
// Port-level checker for the fractional delay ring buffer, bound to the top.
`timescale 1ns / 1ps
module fdrb_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input fdrb_pkg::req_t in_data_i,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input fdrb_pkg::rsp_t out_data_o
);

  // a stalled response transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("response changed while stalled");

  // one request in flight: the block stalls right after taking one
  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken while another is in flight");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.status == fdrb_pkg::STATUS_OK ||
                    out_data_o.status == fdrb_pkg::STATUS_OVERRUN ||
                    out_data_o.status == fdrb_pkg::STATUS_UNDERRUN)
    else $error("bad status code");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != fdrb_pkg::STATUS_OK
      |-> out_data_o.sample_out == '0)
    else $error("nonzero sample on error status");

endmodule

bind fractional_delay_ring_buffer fdrb_checker u_fdrb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// ===== dv/fractional_delay_ring_buffer_tb.sv =====
// Self-checking testbench for the fractional delay ring buffer.
`timescale 1ns / 1ps
module fractional_delay_ring_buffer_tb;

  localparam int DEPTH          = 1024;
  localparam int NUM_CH         = 2;
  localparam int PTR_BITS       = $clog2(DEPTH);
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int TAIL_CYCLES    = 32;
  localparam int REQ_W          = fdrb_pkg::REQ_BITS;
  localparam int CH_W           = fdrb_pkg::CHAN_BITS;
  localparam int SMP_W          = fdrb_pkg::SAMPLE_BITS;
  localparam int FRC_W          = fdrb_pkg::FRAC_BITS;
  localparam int DLY_W          = fdrb_pkg::DELAY_BITS;
  localparam int WHL_W          = fdrb_pkg::WHOLE_BITS;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid  = 1'b0;
  logic out_stall = 1'b0;
  fdrb_pkg::req_t in_data = '0;
  logic in_stall;
  logic out_valid;
  fdrb_pkg::rsp_t out_data;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned err_count     = 0;
  int unsigned quiet_cycles  = 0;

  // Shadow copy of the rings and per-channel pointers.
  logic signed [SMP_W-1:0] ring_mem [NUM_CH][DEPTH];
  logic [PTR_BITS-1:0] wr_ptr  [NUM_CH];
  logic [PTR_BITS-1:0] rd_ptr  [NUM_CH];
  logic [FRC_W-1:0]    rd_frac [NUM_CH];

  fdrb_pkg::rsp_t ring_replies_q[$];
  fdrb_pkg::rsp_t reply_due;

  fractional_delay_ring_buffer #(
    .BUFFER_DEPTH(DEPTH),
    .NUM_CHANNELS(NUM_CH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Apply one request to the shadow state and return the response it owes.
  function automatic fdrb_pkg::rsp_t ring_access(input fdrb_pkg::req_t r);
    fdrb_pkg::rsp_t rsp;
    int ch;
    int s1;
    int s2;
    int prod;
    logic [WHL_W-1:0] whole;
    logic [PTR_BITS-1:0] nxt;
    rsp   = '0;
    ch    = r.channel;
    whole = r.delay_amount[DLY_W-1:FRC_W];
    case (r.req_type)
      fdrb_pkg::REQ_WRITE: begin
        nxt = wr_ptr[ch] + 1'b1;
        if (nxt == rd_ptr[ch]) begin
          rsp.status = fdrb_pkg::STATUS_OVERRUN;
        end else begin
          ring_mem[ch][wr_ptr[ch]] = r.sample_in;
          wr_ptr[ch] = nxt;
        end
      end
      fdrb_pkg::REQ_READ: begin
        if (rd_ptr[ch] == wr_ptr[ch]) begin
          rsp.status = fdrb_pkg::STATUS_UNDERRUN;
        end else begin
          s1 = ring_mem[ch][rd_ptr[ch]];
          s2 = ring_mem[ch][PTR_BITS'(rd_ptr[ch] + 1'b1)];
          prod = int'(rd_frac[ch]) * (s2 - s1);
          // arithmetic shift of the product is a floor
          rsp.sample_out = SMP_W'(s1 + (prod >>> FRC_W));
          rd_ptr[ch] = rd_ptr[ch] + 1'b1;
        end
      end
      fdrb_pkg::REQ_SET_DELAY: begin
        rd_ptr[ch]  = wr_ptr[ch] - PTR_BITS'(whole);
        rd_frac[ch] = r.delay_amount[FRC_W-1:0];
      end
      fdrb_pkg::REQ_ADV_WRITE: begin
        wr_ptr[ch] = wr_ptr[ch] + PTR_BITS'(whole);
      end
      fdrb_pkg::REQ_CLEAR: begin
        // fraction survives a clear
        foreach (ring_mem[c, a]) ring_mem[c][a] = '0;
        foreach (wr_ptr[c]) begin
          wr_ptr[c] = '0;
          rd_ptr[c] = '0;
        end
      end
      default: ;
    endcase
    return rsp;
  endfunction

  function automatic fdrb_pkg::req_t mk_req(input logic [REQ_W-1:0] op, input int ch,
                                            input int smp, input int whole,
                                            input int frac);
    fdrb_pkg::req_t r;
    r.req_type     = op;
    r.channel      = CH_W'(ch);
    r.sample_in    = SMP_W'(smp);
    r.delay_amount = {WHL_W'(whole), FRC_W'(frac)};
    return r;
  endfunction

  function automatic fdrb_pkg::req_t rand_req();
    fdrb_pkg::req_t r;
    int unsigned pick;
    pick        = $urandom_range(999);
    r.channel   = CH_W'($urandom_range(NUM_CH - 1));
    r.sample_in = SMP_W'($urandom);
    if ($urandom_range(9) == 0) begin
      r.sample_in = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
    end
    r.delay_amount = DLY_W'($urandom);
    // mostly short delays so reads land on freshly written samples
    if ($urandom_range(3) != 0) begin
      r.delay_amount[DLY_W-1:FRC_W] = WHL_W'($urandom_range(12));
    end
    if (pick < 400) begin
      r.req_type = fdrb_pkg::REQ_WRITE;
    end else if (pick < 800) begin
      r.req_type = fdrb_pkg::REQ_READ;
    end else if (pick < 900) begin
      r.req_type = fdrb_pkg::REQ_SET_DELAY;
    end else if (pick < 960) begin
      r.req_type = fdrb_pkg::REQ_ADV_WRITE;
    end else if (pick < 965) begin
      r.req_type = fdrb_pkg::REQ_CLEAR;
    end else begin
      r.req_type = REQ_W'($urandom_range(2**REQ_W - 1, int'(fdrb_pkg::REQ_CLEAR) + 1));
    end
    return r;
  endfunction

  // Present one request; valid stays up after the transaction so that
  // back-to-back requests can follow without valid dropping.
  task automatic send_req(input fdrb_pkg::req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk_i);
    while (in_stall !== 1'b0) @(posedge clk_i);
    ring_replies_q.push_back(ring_access(r));
  endtask

  task automatic wait_replies_done();
    in_valid <= 1'b0;
    while (ring_replies_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed_corners();
    fdrb_pkg::req_t seq[$];
    seq.push_back(mk_req(fdrb_pkg::REQ_READ,      0, 0,      0,    0));   // empty ring
    seq.push_back(mk_req(fdrb_pkg::REQ_WRITE,     0, 32767,  0,    0));
    seq.push_back(mk_req(fdrb_pkg::REQ_WRITE,     0, -32768, 0,    0));
    seq.push_back(mk_req(fdrb_pkg::REQ_WRITE,     0, 0,      0,    0));
    seq.push_back(mk_req(fdrb_pkg::REQ_SET_DELAY, 0, 0,      3,    255));
    seq.push_back(mk_req(fdrb_pkg::REQ_READ,      0, 0,      0,    0));   // full-scale swing
    seq.push_back(mk_req(fdrb_pkg::REQ_READ,      0, 0,      0,    0));
    seq.push_back(mk_req(fdrb_pkg::REQ_READ,      0, 0,      0,    0));
    seq.push_back(mk_req(fdrb_pkg::REQ_READ,      0, 0,      0,    0));   // drained
    seq.push_back(mk_req(fdrb_pkg::REQ_SET_DELAY, 0, 0,      2,    0));
    seq.push_back(mk_req(fdrb_pkg::REQ_READ,      0, 0,      0,    0));   // zero fraction
    seq.push_back(mk_req(fdrb_pkg::REQ_SET_DELAY, 1, 0,      1023, 255)); // rp just past wp
    seq.push_back(mk_req(fdrb_pkg::REQ_WRITE,     1, 32767,  0,    0));   // overrun
    seq.push_back(mk_req(fdrb_pkg::REQ_ADV_WRITE, 1, 0,      1022, 171));
    seq.push_back(mk_req(fdrb_pkg::REQ_WRITE,     1, -32768, 0,    0));
    seq.push_back(mk_req(fdrb_pkg::REQ_WRITE,     1, 4660,   0,    0));   // wraps to zero
    seq.push_back(mk_req(fdrb_pkg::REQ_WRITE,     1, 32767,  0,    0));   // overrun again
    seq.push_back(mk_req(fdrb_pkg::REQ_READ,      1, 0,      0,    0));
    seq.push_back(mk_req(REQ_W'(int'(fdrb_pkg::REQ_CLEAR) + 1), 1, -1, 1023, 255));
    seq.push_back(mk_req(REQ_W'(2**REQ_W - 1),    0, -1,     1023, 255));
    seq.push_back(mk_req(fdrb_pkg::REQ_CLEAR,     1, 0,      0,    0));
    seq.push_back(mk_req(fdrb_pkg::REQ_READ,      1, 0,      0,    0));   // empty after clear
    seq.push_back(mk_req(fdrb_pkg::REQ_WRITE,     1, -32768, 0,    0));
    seq.push_back(mk_req(fdrb_pkg::REQ_WRITE,     1, 32767,  0,    0));
    seq.push_back(mk_req(fdrb_pkg::REQ_READ,      1, 0,      0,    0));   // kept fraction
    foreach (seq[i]) send_req(seq[i]);
    wait_replies_done();
  endtask

  task automatic test_random_traffic(input int unsigned tx_pct, input int unsigned rx_pct,
                                     input int num_items);
    send_idle_pct = tx_pct;
    recv_idle_pct = rx_pct;
    repeat (num_items) send_req(rand_req());
    wait_replies_done();
  endtask

  // Sender holds off until the block has answered everything outstanding.
  task automatic test_pause_drain();
    repeat (20) begin
      repeat ($urandom_range(1, 6)) send_req(rand_req());
      wait_replies_done();
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      if (ring_replies_q.size() == 0) begin
        $error("response with no request outstanding: sample_out %0d status %0d",
               out_data.sample_out, out_data.status);
        err_count++;
      end else begin
        reply_due = ring_replies_q.pop_front();
        if (out_data.sample_out !== reply_due.sample_out) begin
          $error("sample_out: expected %0d, got %0d", reply_due.sample_out,
                 out_data.sample_out);
          err_count++;
        end
        if (out_data.status !== reply_due.status) begin
          $error("status: expected %0d, got %0d", reply_due.status, out_data.status);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    foreach (ring_mem[c, a]) ring_mem[c][a] = '0;
    foreach (wr_ptr[c]) begin
      wr_ptr[c]  = '0;
      rd_ptr[c]  = '0;
      rd_frac[c] = '0;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    send_idle_pct = 21;
    recv_idle_pct = 66;
    test_directed_corners();
    test_random_traffic(21, 66, 700);
    test_pause_drain();
    test_random_traffic(66, 21, 700);
    test_random_traffic(0, 0, 550);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/fdrb_pkg.sv
hdl/fdrb_ram.sv
hdl/fdrb_alu.sv
hdl/fractional_delay_ring_buffer.sv
hdl/fdrb_checker.sv
dv/fractional_delay_ring_buffer_tb.sv
